/* sv/tgvg_pkg.sv */
// Shared types, constants and arithmetic helpers of the torus grid vertex generator.
package tgvg_pkg;

  localparam int DEF_MAX_DIVISIONS = 256;
  localparam int DEF_COORD_BITS    = 24;
  localparam int SQRT_STAGES       = 32;
  localparam int QUOT_BITS         = 18;

  typedef enum logic [2:0] {
    REG_DETAIL_LEVEL  = 3'd0,
    REG_RING_RADIUS   = 3'd1,
    REG_TUBE_RADIUS   = 3'd2,
    REG_SCALE_X       = 3'd3,
    REG_SCALE_Y       = 3'd4,
    REG_SCALE_Z       = 3'd5,
    REG_TEX_SCALE     = 3'd6,
    REG_ATTR_OPTIONS  = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    TEX_NONE = 2'd0,
    TEX_UV   = 2'd1,
    TEX_CUBE = 2'd2,
    TEX_RSVD = 2'd3
  } tex_mode_t;

  typedef struct packed {
    logic [1:0]         detail;
    logic signed [23:0] ring_radius;
    logic signed [23:0] tube_radius;
    logic signed [23:0] scale_x;
    logic signed [23:0] scale_y;
    logic signed [23:0] scale_z;
    logic [31:0]        tex_scale;
    logic [3:0]         options;
  } cfg_t;

  // Fields that travel alongside the length and division pipelines.
  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic [23:0]        nx;
    logic [23:0]        ny;
    logic [23:0]        nz;
    logic [23:0]        tu;
    logic [23:0]        tv;
    logic [23:0]        tgx;
    logic [23:0]        tgz;
    logic [16:0]        idx;
  } side_t;

  // First quadrant of the sine in Q1.16, 64 steps per quarter turn.
  function automatic logic [16:0] quarter_sine(input logic [6:0] r);
    logic [16:0] v;
    case (r)
      7'd0: v = 17'd0;      7'd1: v = 17'd1608;   7'd2: v = 17'd3216;   7'd3: v = 17'd4821;
      7'd4: v = 17'd6424;   7'd5: v = 17'd8022;   7'd6: v = 17'd9616;   7'd7: v = 17'd11204;
      7'd8: v = 17'd12785;  7'd9: v = 17'd14359;  7'd10: v = 17'd15924; 7'd11: v = 17'd17479;
      7'd12: v = 17'd19024; 7'd13: v = 17'd20557; 7'd14: v = 17'd22078; 7'd15: v = 17'd23586;
      7'd16: v = 17'd25080; 7'd17: v = 17'd26558; 7'd18: v = 17'd28020; 7'd19: v = 17'd29466;
      7'd20: v = 17'd30893; 7'd21: v = 17'd32303; 7'd22: v = 17'd33692; 7'd23: v = 17'd35062;
      7'd24: v = 17'd36410; 7'd25: v = 17'd37736; 7'd26: v = 17'd39040; 7'd27: v = 17'd40320;
      7'd28: v = 17'd41576; 7'd29: v = 17'd42806; 7'd30: v = 17'd44011; 7'd31: v = 17'd45190;
      7'd32: v = 17'd46341; 7'd33: v = 17'd47464; 7'd34: v = 17'd48559; 7'd35: v = 17'd49624;
      7'd36: v = 17'd50660; 7'd37: v = 17'd51665; 7'd38: v = 17'd52639; 7'd39: v = 17'd53581;
      7'd40: v = 17'd54491; 7'd41: v = 17'd55368; 7'd42: v = 17'd56212; 7'd43: v = 17'd57022;
      7'd44: v = 17'd57798; 7'd45: v = 17'd58538; 7'd46: v = 17'd59244; 7'd47: v = 17'd59914;
      7'd48: v = 17'd60547; 7'd49: v = 17'd61145; 7'd50: v = 17'd61705; 7'd51: v = 17'd62228;
      7'd52: v = 17'd62714; 7'd53: v = 17'd63162; 7'd54: v = 17'd63572; 7'd55: v = 17'd63944;
      7'd56: v = 17'd64277; 7'd57: v = 17'd64571; 7'd58: v = 17'd64827; 7'd59: v = 17'd65043;
      7'd60: v = 17'd65220; 7'd61: v = 17'd65358; 7'd62: v = 17'd65457; 7'd63: v = 17'd65516;
      7'd64: v = 17'd65536;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [17:0] sine_at(input logic [7:0] phase);
    logic [6:0]  r;
    logic [16:0] m;
    r = {1'b0, phase[5:0]};
    m = phase[6] ? quarter_sine(7'd64 - r) : quarter_sine(r);
    return phase[7] ? -$signed({1'b0, m}) : $signed({1'b0, m});
  endfunction

  // Round a Q.32 product back to Q.16: add half, floor shift.
  function automatic logic signed [47:0] rnd16(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = (p + 64'sd32768) >>> 16;
    return t[47:0];
  endfunction

endpackage

/* sv/tgvg_front.sv */
// Front pipeline: trig lookup, position, normal, texture and squared length.
module tgvg_front import tgvg_pkg::*; #(
  parameter int MAX_DIVISIONS = DEF_MAX_DIVISIONS,
  parameter int COORD_BITS    = DEF_COORD_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  cfg_t        cfg,
  input  logic        in_v,
  input  logic [8:0]  in_ring,
  input  logic [8:0]  in_tube,
  output logic        out_v,
  output logic [63:0] out_sq,
  output side_t       out_side
);

  function automatic int lg_cap(input int maxd);
    int c;
    c = 8;
    while (c > 2 && (1 << c) > maxd) c = c - 2;
    return c;
  endfunction

  localparam int LG_CAP = lg_cap(MAX_DIVISIONS);
  localparam logic signed [47:0] SAT_HI = 48'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
  localparam logic signed [47:0] SAT_LO = -SAT_HI - 48'sd1;

  function automatic logic signed [31:0] sat(input logic signed [47:0] v);
    logic signed [47:0] t;
    t = (v > SAT_HI) ? SAT_HI : ((v < SAT_LO) ? SAT_LO : v);
    return t[31:0];
  endfunction

  logic [3:0] lg;
  logic [8:0] n;
  logic [8:0] ic, jc;
  logic [14:0] iph, jph;

  always_comb begin
    lg  = (4'd2 + {1'b0, cfg.detail, 1'b0} > 4'(LG_CAP)) ? 4'(LG_CAP)
        : 4'd2 + {1'b0, cfg.detail, 1'b0};
    n   = 9'd1 << lg;
    ic  = (in_ring > n) ? n : in_ring;
    jc  = (in_tube > n) ? n : in_tube;
    iph = {6'd0, ic} << (4'd8 - lg);
    jph = {6'd0, jc} << (4'd8 - lg);
  end

  // Stage 1: angles.
  logic v1_r;
  logic signed [17:0] st1_r, ct1_r, sp1_r, cp1_r;
  logic [8:0] i1_r, j1_r;
  logic [16:0] idx1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (adv) v1_r <= in_v;
    if (adv) begin
      st1_r  <= sine_at(iph[7:0]);
      ct1_r  <= sine_at(iph[7:0] + 8'd64);
      sp1_r  <= sine_at(jph[7:0]);
      cp1_r  <= sine_at(jph[7:0] + 8'd64);
      i1_r   <= ic;
      j1_r   <= jc;
      idx1_r <= (17'(ic) << lg) + 17'(ic) + 17'(jc);
    end
  end

  // Stage 2: tube offsets, normal products, uv.
  logic v2_r;
  logic signed [17:0] st2_r, ct2_r, sp2_r;
  logic signed [24:0] tcp2_r, tsp2_r;
  logic signed [17:0] ncx2_r, ncz2_r;
  logic [23:0] tu2_r, tv2_r;
  logic [16:0] idx2_r;
  logic [28:0] uprod, vprod;

  always_comb begin
    uprod = (29'(i1_r) * 29'(cfg.tex_scale[31:16]) << 4) + 29'(n >> 1);
    vprod = (29'(j1_r) * 29'(cfg.tex_scale[15:0]) << 4) + 29'(n >> 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (adv) v2_r <= v1_r;
    if (adv) begin
      st2_r  <= st1_r;
      ct2_r  <= ct1_r;
      sp2_r  <= sp1_r;
      tcp2_r <= 25'(rnd16(64'(cfg.tube_radius) * 64'(cp1_r)));
      tsp2_r <= 25'(rnd16(64'(cfg.tube_radius) * 64'(sp1_r)));
      ncx2_r <= 18'(rnd16(64'(cp1_r) * 64'(ct1_r)));
      ncz2_r <= 18'(rnd16(64'(cp1_r) * 64'(st1_r)));
      tu2_r  <= 24'(uprod >> lg);
      tv2_r  <= 24'(vprod >> lg);
      idx2_r <= idx1_r;
    end
  end

  // Stage 3: ring radius at this tube angle, rotated about the axis.
  logic v3_r;
  logic signed [27:0] mrc3_r, mrs3_r;
  logic signed [31:0] py3_r;
  side_t s3_r;
  logic signed [25:0] rad;

  always_comb rad = 26'(cfg.ring_radius) + 26'(tcp2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (adv) v3_r <= v2_r;
    if (adv) begin
      mrc3_r   <= 28'(rnd16(64'(rad) * 64'(ct2_r)));
      mrs3_r   <= 28'(rnd16(64'(rad) * 64'(st2_r)));
      py3_r    <= sat(rnd16(64'(tsp2_r) * 64'(cfg.scale_y)));
      s3_r.px  <= '0;
      s3_r.py  <= '0;
      s3_r.pz  <= '0;
      s3_r.nx  <= 24'(ncx2_r);
      s3_r.ny  <= 24'(sp2_r);
      s3_r.nz  <= 24'(ncz2_r);
      s3_r.tu  <= tu2_r;
      s3_r.tv  <= tv2_r;
      s3_r.tgx <= 24'(-19'(st2_r));
      s3_r.tgz <= 24'(ct2_r);
      s3_r.idx <= idx2_r;
    end
  end

  // Stage 4: axis scales and saturation.
  logic v4_r;
  side_t s4_r;
  side_t s4_nxt;

  always_comb begin
    s4_nxt    = s3_r;
    s4_nxt.px = sat(rnd16(64'(mrc3_r) * 64'(cfg.scale_x)));
    s4_nxt.py = py3_r;
    s4_nxt.pz = sat(rnd16(64'(mrs3_r) * 64'(cfg.scale_z)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (adv) v4_r <= v3_r;
    if (adv) begin
      s4_r <= s4_nxt;
    end
  end

  // Stage 5: squares.
  logic v5_r;
  side_t s5_r;
  logic [63:0] qx5_r, qy5_r, qz5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else if (adv) v5_r <= v4_r;
    if (adv) begin
      s5_r  <= s4_r;
      qx5_r <= 64'(64'(s4_r.px) * 64'(s4_r.px));
      qy5_r <= 64'(64'(s4_r.py) * 64'(s4_r.py));
      qz5_r <= 64'(64'(s4_r.pz) * 64'(s4_r.pz));
    end
  end

  // Stage 6: sum with seven extra fraction bits of length (14 of square).
  logic v6_r;
  side_t s6_r;
  logic [63:0] sq6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v6_r <= 1'b0;
    else if (adv) v6_r <= v5_r;
    if (adv) begin
      s6_r  <= s5_r;
      sq6_r <= (qx5_r + qy5_r + qz5_r) << 14;
    end
  end

  assign out_v    = v6_r;
  assign out_sq   = sq6_r;
  assign out_side = s6_r;

endmodule

/* sv/tgvg_sqrt.sv */
// Pipelined integer square root, one result bit per stage.
module tgvg_sqrt import tgvg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  logic        in_v,
  input  logic [63:0] in_x,
  input  side_t       in_side,
  output logic        out_v,
  output logic [31:0] out_len,
  output side_t       out_side
);

  logic        v_r   [SQRT_STAGES];
  logic [63:0] x_r   [SQRT_STAGES];
  logic [63:0] res_r [SQRT_STAGES];
  side_t       s_r   [SQRT_STAGES];

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
    localparam logic [63:0] BITK = 64'd1 << (62 - 2 * k);
    logic        vi;
    logic [63:0] xi, ri, trial;
    side_t       si;

    if (k == 0) begin : g_first
      assign vi = in_v;
      assign xi = in_x;
      assign ri = '0;
      assign si = in_side;
    end else begin : g_next
      assign vi = v_r[k-1];
      assign xi = x_r[k-1];
      assign ri = res_r[k-1];
      assign si = s_r[k-1];
    end

    assign trial = ri + BITK;

    always_ff @(posedge clk) begin
      if (!rst_n) v_r[k] <= 1'b0;
      else if (adv) v_r[k] <= vi;
      if (adv) begin
        s_r[k] <= si;
        if (xi >= trial) begin
          x_r[k]   <= xi - trial;
          res_r[k] <= (ri >> 1) + BITK;
        end else begin
          x_r[k]   <= xi;
          res_r[k] <= ri >> 1;
        end
      end
    end
  end

  assign out_v    = v_r[SQRT_STAGES-1];
  assign out_len  = res_r[SQRT_STAGES-1][31:0];
  assign out_side = s_r[SQRT_STAGES-1];

endmodule

/* sv/tgvg_div.sv */
// Three-lane pipelined restoring divider for the cube-mode direction.
module tgvg_div import tgvg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  logic        in_v,
  input  logic [31:0] in_len,
  input  side_t       in_side,
  output logic        out_v,
  output logic [23:0] out_dx,
  output logic [23:0] out_dy,
  output logic [23:0] out_dz,
  output side_t       out_side
);

  // Setup stage: magnitudes, rounding offset, signs.
  logic        v0_r;
  side_t       s0_r;
  logic [31:0] den0_r;
  logic [63:0] num0_r [3];
  logic [2:0]  neg0_r;
  logic [31:0] mag [3];

  always_comb begin
    mag[0] = in_side.px[31] ? 32'(-in_side.px) : 32'(in_side.px);
    mag[1] = in_side.py[31] ? 32'(-in_side.py) : 32'(in_side.py);
    mag[2] = in_side.pz[31] ? 32'(-in_side.pz) : 32'(in_side.pz);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else if (adv) v0_r <= in_v;
    if (adv) begin
      s0_r   <= in_side;
      den0_r <= in_len;
      neg0_r <= {in_side.pz[31], in_side.py[31], in_side.px[31]};
      for (int l = 0; l < 3; l++) num0_r[l] <= (64'(mag[l]) << 23) + 64'(in_len >> 1);
    end
  end

  logic        v_r   [QUOT_BITS];
  side_t       s_r   [QUOT_BITS];
  logic [31:0] den_r [QUOT_BITS];
  logic [2:0]  neg_r [QUOT_BITS];
  logic [63:0] rem_r [QUOT_BITS][3];
  logic [QUOT_BITS-1:0] q_r [QUOT_BITS][3];

  for (genvar k = 0; k < QUOT_BITS; k++) begin : g_stage
    localparam int SH = QUOT_BITS - 1 - k;
    logic        vi;
    side_t       si;
    logic [31:0] di;
    logic [2:0]  ni;
    logic [63:0] ri [3];
    logic [QUOT_BITS-1:0] qi [3];
    logic [63:0] dsh;

    if (k == 0) begin : g_first
      assign vi = v0_r;
      assign si = s0_r;
      assign di = den0_r;
      assign ni = neg0_r;
      for (genvar l = 0; l < 3; l++) begin : g_l
        assign ri[l] = num0_r[l];
        assign qi[l] = '0;
      end
    end else begin : g_next
      assign vi = v_r[k-1];
      assign si = s_r[k-1];
      assign di = den_r[k-1];
      assign ni = neg_r[k-1];
      for (genvar l = 0; l < 3; l++) begin : g_l
        assign ri[l] = rem_r[k-1][l];
        assign qi[l] = q_r[k-1][l];
      end
    end

    assign dsh = 64'(di) << SH;

    always_ff @(posedge clk) begin
      if (!rst_n) v_r[k] <= 1'b0;
      else if (adv) v_r[k] <= vi;
      if (adv) begin
        s_r[k]   <= si;
        den_r[k] <= di;
        neg_r[k] <= ni;
        for (int l = 0; l < 3; l++) begin
          if (ri[l] >= dsh) begin
            rem_r[k][l] <= ri[l] - dsh;
            q_r[k][l]   <= qi[l] | (QUOT_BITS'(1) << SH);
          end else begin
            rem_r[k][l] <= ri[l];
            q_r[k][l]   <= qi[l];
          end
        end
      end
    end
  end

  localparam int L = QUOT_BITS - 1;

  function automatic logic [23:0] signed_q(input logic [QUOT_BITS-1:0] q, input logic neg,
                                           input logic zero);
    logic [23:0] m;
    m = 24'(q);
    return zero ? 24'd0 : (neg ? -m : m);
  endfunction

  assign out_v    = v_r[L];
  assign out_side = s_r[L];
  assign out_dx   = signed_q(q_r[L][0], neg_r[L][0], den_r[L] == 32'd0);
  assign out_dy   = signed_q(q_r[L][1], neg_r[L][1], den_r[L] == 32'd0);
  assign out_dz   = signed_q(q_r[L][2], neg_r[L][2], den_r[L] == 32'd0);

endmodule

/* sv/torus_grid_vertex_generator_core.sv */
// Top level of the torus grid vertex generator: config registers, pipeline, output register.
// Throughput: one item per cycle while the output is not stalled; the length takes
// 32 root stages and the cube direction 19 divider stages, all fully pipelined.
// A stalled output holds the whole pipeline in place; nothing is dropped or repeated.
// Reset (rst_n low, synchronous) clears all valid bits and loads the register defaults.
module torus_grid_vertex_generator_core import tgvg_pkg::*; #(
  parameter int MAX_DIVISIONS = DEF_MAX_DIVISIONS,
  parameter int COORD_BITS    = DEF_COORD_BITS
) (
  input  logic         clk,
  input  logic         rst_n,
  // Input item: ring_step [8:0], tube_step [17:9], zero fill [23:18].
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [23:0]  in_tdata,
  // Result item: pos_x, pos_y, pos_z, normal_x, normal_y, normal_z, tex_u, tex_v,
  // tex_w, tangent_x, tangent_z at 24 bits each from bit 0 up, then
  // cell_first_index [280:264], zero fill [287:281].
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [287:0] out_tdata,
  // Register writes.
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  // Configuration registers. Writes must come only while the block is idle; the block
  // itself does not enforce this. The pipeline reads them live at every stage.
  cfg_t cfg_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.detail      <= 2'd0;
      cfg_r.ring_radius <= 24'sd65536;
      cfg_r.tube_radius <= 24'sd32768;
      cfg_r.scale_x     <= 24'sd65536;
      cfg_r.scale_y     <= 24'sd65536;
      cfg_r.scale_z     <= 24'sd65536;
      cfg_r.tex_scale   <= 32'h1000_1000;
      cfg_r.options     <= 4'd5;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_DETAIL_LEVEL: cfg_r.detail      <= cfg_data[1:0];
        REG_RING_RADIUS:  cfg_r.ring_radius <= cfg_data[23:0];
        REG_TUBE_RADIUS:  cfg_r.tube_radius <= cfg_data[23:0];
        REG_SCALE_X:      cfg_r.scale_x     <= cfg_data[23:0];
        REG_SCALE_Y:      cfg_r.scale_y     <= cfg_data[23:0];
        REG_SCALE_Z:      cfg_r.scale_z     <= cfg_data[23:0];
        REG_TEX_SCALE:    cfg_r.tex_scale   <= cfg_data;
        REG_ATTR_OPTIONS: cfg_r.options     <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline moves together whenever the output register is free
  // or being emptied this cycle.
  logic adv;
  logic out_tvalid_r;
  logic [287:0] out_tdata_r;

  assign adv       = !out_tvalid_r || out_tready;
  assign in_tready = adv;

  logic        f_v;
  logic [63:0] f_sq;
  side_t       f_side;

  tgvg_front #(
    .MAX_DIVISIONS(MAX_DIVISIONS),
    .COORD_BITS   (COORD_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .cfg     (cfg_r),
    .in_v    (in_tvalid && in_tready),
    .in_ring (in_tdata[8:0]),
    .in_tube (in_tdata[17:9]),
    .out_v   (f_v),
    .out_sq  (f_sq),
    .out_side(f_side)
  );

  logic        r_v;
  logic [31:0] r_len;
  side_t       r_side;

  tgvg_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_v    (f_v),
    .in_x    (f_sq),
    .in_side (f_side),
    .out_v   (r_v),
    .out_len (r_len),
    .out_side(r_side)
  );

  logic        d_v;
  logic [23:0] d_x, d_y, d_z;
  side_t       d_side;

  tgvg_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_v    (r_v),
    .in_len  (r_len),
    .in_side (r_side),
    .out_v   (d_v),
    .out_dx  (d_x),
    .out_dy  (d_y),
    .out_dz  (d_z),
    .out_side(d_side)
  );

  // Final selection by the attribute options.
  logic [23:0] nx, ny, nz, tu, tv, tw, tgx, tgz;

  always_comb begin
    nx = '0; ny = '0; nz = '0;
    tu = '0; tv = '0; tw = '0;
    tgx = '0; tgz = '0;
    if (cfg_r.options[2]) begin
      nx = d_side.nx;
      ny = d_side.ny;
      nz = d_side.nz;
    end
    if (cfg_r.options[3]) begin
      tgx = d_side.tgx;
      tgz = d_side.tgz;
    end
    case (tex_mode_t'(cfg_r.options[1:0]))
      TEX_UV: begin
        tu = d_side.tu;
        tv = d_side.tv;
      end
      TEX_CUBE: begin
        tu = d_x;
        tv = d_y;
        tw = d_z;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_tvalid_r <= 1'b0;
    else if (adv) out_tvalid_r <= d_v;
    if (adv) begin
      out_tdata_r <= {7'd0, d_side.idx, tgz, tgx, tw, tv, tu, nz, ny, nx,
                      d_side.pz[23:0], d_side.py[23:0], d_side.px[23:0]};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // A waiting result must hold back new input items.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input accepted while result stalled");

  // The vertex index never exceeds the last point of a 256-step grid.
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[280:264] <= 17'd66048)
    else $error("cell index out of range");

  // Disabled normals leave all three normal fields zero.
  a_normal_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !cfg_r.options[2] |-> out_tdata[143:72] == 72'd0)
    else $error("normal not zero while disabled");

  // Texture mode none, and the reserved mode, give zero texture coordinates.
  a_tex_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (cfg_r.options[1:0] == TEX_NONE || cfg_r.options[1:0] == TEX_RSVD)
    |-> out_tdata[215:144] == 72'd0)
    else $error("texture not zero in none mode");

endmodule
